FILE: sv/ssq_pkg.sv
// Package with the status codes, slider state types and switch classification.
package ssq_pkg;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_UPPER   = 3'd1,
        ST_LOWER   = 3'd2,
        ST_BOTH    = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    localparam int MV_W     = 12;
    localparam int BASE_W   = 13;
    localparam int COUNT_W  = 9;
    localparam int FOLLOW_W = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF_BELOW   = 3'd0,
        CFG_UPPER_BELOW = 3'd1,
        CFG_LOWER_BELOW = 3'd2,
        CFG_MOVE_THRESH = 3'd3,
        CFG_FOLLOW      = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic                        own;
        logic                        other;
        logic signed [COUNT_W-1:0]   count;
    } t_move;

    function automatic t_status classify_switch(
        input logic [MV_W-1:0] mv,
        input logic [MV_W-1:0] off_below,
        input logic [MV_W-1:0] upper_below,
        input logic [MV_W-1:0] lower_below
    );
        t_status res;
        if (mv < off_below) begin
            res = ST_OFF;
        end else if (mv < upper_below) begin
            res = ST_UPPER;
        end else if (mv < lower_below) begin
            res = ST_LOWER;
        end else begin
            res = ST_BOTH;
        end
        return res;
    endfunction

endpackage

FILE: sv/ssq_history.sv
// Switch class ring and qualified switch status.
module ssq_history
    import ssq_pkg::*;
#(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_status i_class,
    output t_status o_status,
    output logic    o_changed
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    t_status           r_hist [HISTORY_DEPTH];
    t_status           n_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    t_status           r_status;
    logic              match;

    always_comb begin
        if (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + SLOT_W'(1);
        end
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            n_hist[i] = (SLOT_W'(i) == n_slot) ? i_class : r_hist[i];
        end
        match = 1'b1;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
            if (n_hist[i] != n_hist[0]) begin
                match = 1'b0;
            end
        end
        o_changed = match && (r_status != n_hist[0]);
        o_status  = o_changed ? n_hist[0] : r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= ST_INVALID;
            end
            r_slot   <= '0;
            r_status <= ST_INVALID;
        end else if (i_adv) begin
            r_hist   <= n_hist;
            r_slot   <= n_slot;
            r_status <= o_status;
        end
    end

endmodule

FILE: sv/ssq_slider_step.sv
// Move detection and follow-up update for one slider.
module ssq_slider_step
    import ssq_pkg::*;
(
    input  logic                      i_en,
    input  logic signed [BASE_W-1:0]  i_base,
    input  logic [MV_W-1:0]           i_reading,
    input  logic [MV_W-1:0]           i_thresh,
    input  logic [FOLLOW_W-1:0]       i_follow,
    input  t_move                     i_move,
    output t_move                     o_move,
    output logic signed [BASE_W-1:0]  o_base,
    output logic                      o_event
);

    logic signed [BASE_W:0]   diff;
    logic [BASE_W:0]          mag;
    logic signed [COUNT_W-1:0] cnt;

    always_comb begin
        diff = $signed({2'b00, i_reading}) - $signed({i_base[BASE_W-1], i_base});
        mag  = diff[BASE_W] ? (BASE_W + 1)'(-diff) : diff;
        o_event = i_en && (i_move.own || (mag > {2'b00, i_thresh}));
        cnt = i_move.own ? i_move.count : $signed({1'b0, i_follow});
        o_move = i_move;
        o_base = i_base;
        if (o_event) begin
            o_move.own   = cnt > 9'sd0;
            o_move.other = 1'b0;
            o_move.count = (cnt > -9'sd1) ? cnt - 9'sd1 : cnt;
            o_base       = $signed({1'b0, i_reading});
        end
    end

endmodule

FILE: sv/switch_and_slider_qualifier_core.sv
// Top level of the switch and slider qualifier.
// One poll transfer is accepted per clock cycle while the input channel does not stall; its result
// passes through the input register, then the result register, and all qualification is combinational
// between them. The slider state and the shared follow-up counter are updated when the result register
// loads, so consecutive polls stream without gaps. A stalled result register holds the input
// register, and the input channel stalls only when both are full.
module switch_and_slider_qualifier_core
    import ssq_pkg::*;
#(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MV_W-1:0]      i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MV_W-1:0]      i_switch_mv,
    input  logic [MV_W-1:0]      i_slider_a_mv,
    input  logic [MV_W-1:0]      i_slider_b_mv,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_switch_changed,
    output logic [2:0]           o_switch_status,
    output logic                 o_slider_a_event,
    output logic [MV_W-1:0]      o_slider_a_value,
    output logic                 o_slider_b_event,
    output logic [MV_W-1:0]      o_slider_b_value,
    output logic                 o_slow_poll
);

    logic [MV_W-1:0]     r_off_below;
    logic [MV_W-1:0]     r_upper_below;
    logic [MV_W-1:0]     r_lower_below;
    logic [MV_W-1:0]     r_move_thresh;
    logic [FOLLOW_W-1:0] r_follow;

    logic            r_in_valid;
    logic [MV_W-1:0] r_sw;
    logic [MV_W-1:0] r_a;
    logic [MV_W-1:0] r_b;

    logic                      r_out_valid;
    logic                      r_changed;
    t_status                   r_status_out;
    logic                      r_ev_a;
    logic [MV_W-1:0]           r_val_a;
    logic                      r_ev_b;
    logic [MV_W-1:0]           r_val_b;

    logic signed [BASE_W-1:0]  r_base_a;
    logic signed [BASE_W-1:0]  r_base_b;
    logic                      r_mv_a;
    logic                      r_mv_b;
    logic signed [COUNT_W-1:0] r_count;

    logic                      adv;
    t_status                   sw_class;
    t_status                   status;
    logic                      changed;
    logic                      en;
    logic signed [BASE_W-1:0]  base_a_pre;
    logic signed [BASE_W-1:0]  base_b_pre;
    t_move                     move_a_in;
    t_move                     move_a_out;
    t_move                     move_b_in;
    t_move                     move_b_out;
    logic signed [BASE_W-1:0]  n_base_a;
    logic signed [BASE_W-1:0]  n_base_b;
    logic                      ev_a;
    logic                      ev_b;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_below   <= MV_W'(500);
            r_upper_below <= MV_W'(1500);
            r_lower_below <= MV_W'(2500);
            r_move_thresh <= MV_W'(50);
            r_follow      <= FOLLOW_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFF_BELOW:   r_off_below   <= i_cfg_data;
                CFG_UPPER_BELOW: r_upper_below <= i_cfg_data;
                CFG_LOWER_BELOW: r_lower_below <= i_cfg_data;
                CFG_MOVE_THRESH: r_move_thresh <= i_cfg_data;
                CFG_FOLLOW:      r_follow      <= i_cfg_data[FOLLOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_sw <= i_switch_mv;
            r_a  <= i_slider_a_mv;
            r_b  <= i_slider_b_mv;
        end
    end

    assign sw_class = classify_switch(r_sw, r_off_below, r_upper_below, r_lower_below);

    ssq_history #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_class   (sw_class),
        .o_status  (status),
        .o_changed (changed)
    );

    always_comb begin
        en         = status != ST_OFF;
        base_a_pre = changed ? $signed({1'b0, r_a}) : r_base_a;
        base_b_pre = changed ? $signed({1'b0, r_b}) : r_base_b;
        move_a_in.own   = changed ? 1'b0 : r_mv_a;
        move_a_in.other = changed ? 1'b0 : r_mv_b;
        move_a_in.count = r_count;
        move_b_in.own   = move_a_out.other;
        move_b_in.other = move_a_out.own;
        move_b_in.count = move_a_out.count;
    end

    ssq_slider_step u_step_a (
        .i_en      (en),
        .i_base    (base_a_pre),
        .i_reading (r_a),
        .i_thresh  (r_move_thresh),
        .i_follow  (r_follow),
        .i_move    (move_a_in),
        .o_move    (move_a_out),
        .o_base    (n_base_a),
        .o_event   (ev_a)
    );

    ssq_slider_step u_step_b (
        .i_en      (en),
        .i_base    (base_b_pre),
        .i_reading (r_b),
        .i_thresh  (r_move_thresh),
        .i_follow  (r_follow),
        .i_move    (move_b_in),
        .o_move    (move_b_out),
        .o_base    (n_base_b),
        .o_event   (ev_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_a <= -13'sd1;
            r_base_b <= -13'sd1;
            r_mv_a   <= 1'b0;
            r_mv_b   <= 1'b0;
            r_count  <= '0;
        end else if (adv) begin
            r_base_a <= n_base_a;
            r_base_b <= n_base_b;
            r_mv_a   <= move_b_out.other;
            r_mv_b   <= move_b_out.own;
            r_count  <= move_b_out.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_changed    <= changed;
            r_status_out <= status;
            r_ev_a       <= ev_a;
            r_val_a      <= ev_a ? r_a : '0;
            r_ev_b       <= ev_b;
            r_val_b      <= ev_b ? r_b : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_switch_changed = r_changed;
    assign o_switch_status  = r_status_out;
    assign o_slider_a_event = r_ev_a;
    assign o_slider_a_value = r_val_a;
    assign o_slider_b_event = r_ev_b;
    assign o_slider_b_value = r_val_b;
    assign o_slow_poll      = r_status_out == ST_OFF;

endmodule

FILE: sv/ssq_checker.sv
// Port-level checks for the switch and slider qualifier, bound to the top level.
module ssq_checker
    import ssq_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input logic            o_switch_changed,
    input logic [2:0]      o_switch_status,
    input logic            o_slider_a_event,
    input logic [MV_W-1:0] o_slider_a_value,
    input logic            o_slider_b_event,
    input logic [MV_W-1:0] o_slider_b_value,
    input logic            o_slow_poll
);

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_switch_status)
            && $stable(o_slider_a_value) && $stable(o_slider_b_value))
        else $error("result changed while stalled");

    a_slow_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_slow_poll == (o_switch_status == ST_OFF))
        else $error("slow poll does not match off status");

    a_no_event_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_slider_a_event || o_slider_a_value == '0)
            && (o_slider_b_event || o_slider_b_value == '0))
        else $error("slider value reported without an event");

    // A status change resets the baselines to the readings, so no move can be seen.
    a_change_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switch_changed |->
            !o_slider_a_event && !o_slider_b_event && o_switch_status != ST_INVALID)
        else $error("slider event on a switch change");

    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switch_status == ST_OFF |->
            !o_slider_a_event && !o_slider_b_event)
        else $error("slider event while switch is off");

endmodule

bind switch_and_slider_qualifier_core ssq_checker u_ssq_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the switch and slider qualifier with a built-in poll predictor.
`timescale 1ns / 100ps

module testbench;
    import ssq_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RING_DEPTH      = 3;
    localparam int RANDOM_PHASES   = 6;
    localparam int POLLS_PER_PHASE = 87;
    localparam int DRAIN_CYCLES    = 4;

    typedef struct {
        logic            changed;
        t_status         status;
        logic            a_event;
        logic [MV_W-1:0] a_value;
        logic            b_event;
        logic [MV_W-1:0] b_value;
        logic            slow;
    } t_poll_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [MV_W-1:0]      i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic [MV_W-1:0]      i_switch_mv   = '0;
    logic [MV_W-1:0]      i_slider_a_mv = '0;
    logic [MV_W-1:0]      i_slider_b_mv = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic                 o_switch_changed;
    logic [2:0]           o_switch_status;
    logic                 o_slider_a_event;
    logic [MV_W-1:0]      o_slider_a_value;
    logic                 o_slider_b_event;
    logic [MV_W-1:0]      o_slider_b_value;
    logic                 o_slow_poll;

    // Predictor copy of the registers and the qualifier state.
    logic [MV_W-1:0]     lim_off     = 12'd500;
    logic [MV_W-1:0]     lim_upper   = 12'd1500;
    logic [MV_W-1:0]     lim_lower   = 12'd2500;
    logic [MV_W-1:0]     lim_move    = 12'd50;
    logic [FOLLOW_W-1:0] follow_load = 8'd10;
    t_status             zone_ring [RING_DEPTH];
    int                  ring_slot;
    t_status             held_status;
    int                  base_a;
    int                  base_b;
    bit                  moving_a;
    bit                  moving_b;
    int                  follow_left;

    t_poll_result expected_polls [$];
    t_poll_result due_result;
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           stall_left     = 0;
    bit           idling         = 1'b1;

    switch_and_slider_qualifier_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_switch_mv      (i_switch_mv),
        .i_slider_a_mv    (i_slider_a_mv),
        .i_slider_b_mv    (i_slider_b_mv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_switch_changed (o_switch_changed),
        .o_switch_status  (o_switch_status),
        .o_slider_a_event (o_slider_a_event),
        .o_slider_a_value (o_slider_a_value),
        .o_slider_b_event (o_slider_b_event),
        .o_slider_b_value (o_slider_b_value),
        .o_slow_poll      (o_slow_poll)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_status zone_of(input logic [MV_W-1:0] mv);
        if (mv < lim_off) return ST_OFF;
        if (mv < lim_upper) return ST_UPPER;
        if (mv < lim_lower) return ST_LOWER;
        return ST_BOTH;
    endfunction

    function automatic bit over_limit(input int base, input int reading);
        int diff;
        diff = reading - base;
        if (diff < 0) diff = -diff;
        return diff > int'(lim_move);
    endfunction

    // The follow-up counter is shared, so a move of either slider ends the other's run.
    function automatic bit start_follow(input bit was_moving);
        bit own;
        if (!was_moving) follow_left = int'(follow_load);
        moving_a = 1'b0;
        moving_b = 1'b0;
        own = follow_left > 0;
        if (follow_left > -1) follow_left--;
        return own;
    endfunction

    function automatic t_poll_result qualify_poll(input logic [MV_W-1:0] sw,
                                                  input logic [MV_W-1:0] a,
                                                  input logic [MV_W-1:0] b);
        t_poll_result res;
        bit agree;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        zone_ring[ring_slot] = zone_of(sw);
        agree = 1'b1;
        for (int i = 1; i < RING_DEPTH; i++) begin
            if (zone_ring[i] != zone_ring[0]) agree = 1'b0;
        end
        res.changed = 1'b0;
        res.a_event = 1'b0;
        res.b_event = 1'b0;
        if (agree && held_status != zone_ring[0]) begin
            base_a = int'(a);
            base_b = int'(b);
            moving_a = 1'b0;
            moving_b = 1'b0;
            held_status = zone_ring[0];
            res.changed = 1'b1;
        end
        if (held_status != ST_OFF) begin
            if (moving_a || over_limit(base_a, int'(a))) begin
                res.a_event = 1'b1;
                moving_a = start_follow(moving_a);
                base_a = int'(a);
            end
            if (moving_b || over_limit(base_b, int'(b))) begin
                res.b_event = 1'b1;
                moving_b = start_follow(moving_b);
                base_b = int'(b);
            end
        end
        res.status  = held_status;
        res.a_value = res.a_event ? a : '0;
        res.b_value = res.b_event ? b : '0;
        res.slow    = held_status == ST_OFF;
        return res;
    endfunction

    function automatic int nudge(input int mv, input int span);
        int val;
        val = mv + int'($urandom_range(0, 2 * span)) - span;
        if (val < 0) val = 0;
        if (val > 4095) val = 4095;
        return val;
    endfunction

    function automatic int next_slider(input int cur);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return cur;
        if (pick < 85) return nudge(cur, int'(lim_move) + 10);
        return $urandom_range(0, 4095);
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [MV_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_OFF_BELOW:   lim_off = value;
            CFG_UPPER_BELOW: lim_upper = value;
            CFG_LOWER_BELOW: lim_lower = value;
            CFG_MOVE_THRESH: lim_move = value;
            CFG_FOLLOW:      follow_load = value[FOLLOW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [MV_W-1:0] off_mv, input logic [MV_W-1:0] upper_mv,
                                  input logic [MV_W-1:0] lower_mv, input logic [MV_W-1:0] move_mv,
                                  input logic [FOLLOW_W-1:0] follow);
        write_reg(CFG_OFF_BELOW, off_mv);
        write_reg(CFG_UPPER_BELOW, upper_mv);
        write_reg(CFG_LOWER_BELOW, lower_mv);
        write_reg(CFG_MOVE_THRESH, move_mv);
        write_reg(CFG_FOLLOW, {{(MV_W - FOLLOW_W){1'b0}}, follow});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_poll(input int sw, input int a, input int b);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_switch_mv   <= sw[MV_W-1:0];
        i_slider_a_mv <= a[MV_W-1:0];
        i_slider_b_mv <= b[MV_W-1:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_polls.push_back(qualify_poll(sw[MV_W-1:0], a[MV_W-1:0], b[MV_W-1:0]));
    endtask

    task automatic drain_polls();
        i_in_valid <= 1'b0;
        while (expected_polls.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_power_up();
        send_poll(4095, 4095, 0);
        send_poll(0, 0, 4095);
        send_poll(2000, 1, 4094);
        drain_polls();
    endtask

    task automatic test_switch_classes();
        send_poll(0, 10, 3000);
        send_poll(499, 3000, 3010);
        send_poll(250, 20, 3000);
        send_poll(500, 2000, 1000);
        send_poll(1499, 2049, 1051);
        send_poll(1000, 2100, 1000);
        send_poll(1500, 100, 200);
        send_poll(2499, 151, 249);
        send_poll(2000, 151, 251);
        send_poll(2500, 4095, 0);
        send_poll(4095, 4095, 0);
        send_poll(3000, 0, 4095);
        drain_polls();
    endtask

    task automatic test_follow_up();
        apply_settings(12'd500, 12'd1500, 12'd2500, 12'd0, 8'd2);
        send_poll(3000, 100, 4095);
        send_poll(3000, 100, 4095);
        send_poll(3000, 100, 4095);
        send_poll(3000, 200, 4095);
        send_poll(3000, 200, 300);
        send_poll(3000, 200, 300);
        drain_polls();
    endtask

    task automatic test_threshold_order();
        apply_settings(12'd3000, 12'd1000, 12'd2000, 12'd4095, 8'd255);
        send_poll(2500, 0, 4095);
        send_poll(2500, 4095, 0);
        send_poll(2500, 0, 4095);
        send_poll(3500, 4095, 0);
        send_poll(3500, 0, 4095);
        send_poll(3500, 4095, 0);
        drain_polls();
    endtask

    task automatic test_random_polls(input int phase);
        int lim [3];
        int swap;
        int level;
        int run_left;
        int sw;
        int a_mv;
        int b_mv;
        case (phase)
            0: apply_settings(12'd500, 12'd1500, 12'd2500, 12'd50, 8'd10);
            1: apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 8'd0);
            2: apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255);
            default: begin
                for (int i = 0; i < 3; i++) lim[i] = $urandom_range(0, 4095);
                // Phase 4 keeps the thresholds in whatever order they came.
                if (phase != 4) begin
                    for (int i = 0; i < 2; i++) begin
                        for (int j = 0; j < 2 - i; j++) begin
                            if (lim[j] > lim[j + 1]) begin
                                swap = lim[j];
                                lim[j] = lim[j + 1];
                                lim[j + 1] = swap;
                            end
                        end
                    end
                end
                apply_settings(lim[0][MV_W-1:0], lim[1][MV_W-1:0], lim[2][MV_W-1:0],
                               MV_W'($urandom_range(0, 300)), FOLLOW_W'($urandom_range(0, 20)));
            end
        endcase
        a_mv = $urandom_range(0, 4095);
        b_mv = $urandom_range(0, 4095);
        level = 0;
        run_left = 0;
        for (int n = 0; n < POLLS_PER_PHASE; n++) begin
            if (run_left == 0) begin
                level = $urandom_range(0, 4095);
                run_left = ($urandom_range(0, 9) < 7) ? $urandom_range(3, 8) : $urandom_range(1, 2);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) sw = $urandom_range(0, 4095);
            else sw = nudge(level, 30);
            a_mv = next_slider(a_mv);
            b_mv = next_slider(b_mv);
            send_poll(sw, a_mv, b_mv);
        end
        drain_polls();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_polls.size() == 0) begin
                $error("result transfer with no poll outstanding");
                mismatch_count++;
            end else begin
                due_result = expected_polls.pop_front();
                check_field("switch_changed", due_result.changed, o_switch_changed);
                check_field("switch_status", due_result.status, o_switch_status);
                check_field("slider_a_event", due_result.a_event, o_slider_a_event);
                check_field("slider_a_value", due_result.a_value, o_slider_a_value);
                check_field("slider_b_event", due_result.b_event, o_slider_b_event);
                check_field("slider_b_value", due_result.b_value, o_slider_b_value);
                check_field("slow_poll", due_result.slow, o_slow_poll);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < RING_DEPTH; i++) zone_ring[i] = ST_INVALID;
        ring_slot   = 0;
        held_status = ST_INVALID;
        base_a      = -1;
        base_b      = -1;
        moving_a    = 1'b0;
        moving_b    = 1'b0;
        follow_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_up();
        test_switch_classes();
        test_follow_up();
        test_threshold_order();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idling = (p != 3) && (p != RANDOM_PHASES - 1);
            test_random_polls(p);
        end
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
